// ===== src/swm_pkg.sv =====
// Shared types and constants for the sliding-window median filter.
// Used by swm_ctrl, swm_datapath and sliding_window_median_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int WINDOW_MAX_DEF = 7;
    localparam int LEN_BITS       = 3;
    localparam int FILL_BITS      = 3;
    localparam logic [LEN_BITS-1:0] LEN_RESET = 3'd7;

    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef struct packed {
        logic                          func;
        logic signed [SAMPLE_BITS-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] median;
        logic [FILL_BITS-1:0]          fill_count;
        logic                          median_valid;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic push;       // write sample, advance head and count
        logic clear;      // empty the window, zero result
        logic rank_next;  // step to next candidate
        logic capture;    // latch current candidate as the median
        logic load_out;   // move result into output register
    } swm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic found;      // current candidate sits at sorted index count/2
    } swm_stat_t;

endpackage

`default_nettype wire

// ===== src/sliding_window_median_top.sv =====
// Top level of the sliding-window median filter: controller plus datapath.
// Depends on swm_pkg, swm_ctrl and swm_datapath.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------
//  input    | in_valid / in_ready      | in_item  (func, sample)
//  output   | out_valid / out_ready    | out_item (median, fill_count, median_valid)
//  config   | cfg_we (no wait)         | cfg_wdata (window_length)
//
// A push writes the sample, ranks the candidates in turn with the comparator
// bank until the median is found, and then hands off. A clear goes straight to
// the hand-off. The output register lets the next transfer in while
// a result waits. Reset is asynchronous, active low; the window length resets
// to 7. Output stalls hold the block in its hand-off cycle.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_median_top #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire swm_pkg::in_item_t            in_item,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output swm_pkg::out_item_t                out_item,
    input  wire logic                         cfg_we,
    input  wire logic [swm_pkg::LEN_BITS-1:0] cfg_wdata
);

    swm_pkg::swm_cmd_t  cmd;
    swm_pkg::swm_stat_t st;

    swm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_func   (in_item.func),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .st        (st)
    );

    swm_datapath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .st        (st),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

// ===== src/swm_ctrl.sv =====
// Sequencer for the sliding-window median filter: accept, rank, hand off.
// Depends on swm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              in_func,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output swm_pkg::swm_cmd_t      cmd,
    input  wire swm_pkg::swm_stat_t st
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RANK = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       in_xfer;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign in_xfer   = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_func == swm_pkg::FUNC_CLEAR)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        cmd.push   = 1'b1;
                        state_next = ST_RANK;
                    end
                end
            end
            ST_RANK:
            begin
                if (st.found)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_HOLD;
                end
                else
                begin
                    cmd.rank_next = 1'b1;
                end
            end
            ST_HOLD:
            begin
                // output slot free or being drained this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/swm_datapath.sv =====
// Window storage, length register and rank-select datapath for the median filter.
// Depends on swm_pkg; driven by swm_ctrl through swm_cmd_t / swm_stat_t.
`timescale 1ns / 1ps
`default_nettype none

module swm_datapath #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire swm_pkg::in_item_t            in_item,
    input  wire logic                         cfg_we,
    input  wire logic [swm_pkg::LEN_BITS-1:0] cfg_wdata,
    input  wire swm_pkg::swm_cmd_t            cmd,
    output swm_pkg::swm_stat_t                st,
    output swm_pkg::out_item_t                out_item
);

    localparam int SB = swm_pkg::SAMPLE_BITS;
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LW = (CW > swm_pkg::LEN_BITS) ? CW : swm_pkg::LEN_BITS;
    localparam logic [LW-1:0] MAX_W = LW'(WINDOW_MAX);

    logic signed [SB-1:0] window_reg [WINDOW_MAX];

    logic [swm_pkg::LEN_BITS-1:0] len_reg;
    logic [CW-1:0]                head_reg;
    logic [CW-1:0]                head_next;
    logic [CW-1:0]                filled_reg;
    logic [CW-1:0]                filled_next;
    logic [CW-1:0]                cand_reg;
    logic [CW-1:0]                cand_next;

    logic signed [SB-1:0]         res_median_reg;
    logic [CW-1:0]                res_fill_reg;
    logic                         res_valid_reg;
    swm_pkg::out_item_t           out_item_reg;

    logic [LW-1:0]                len_w;
    logic [CW-1:0]                len_eff;
    logic                         cfg_ok;
    logic [CW:0]                  head_inc;
    logic signed [SB-1:0]         cand_val;
    logic [CW-1:0]                less_cnt;
    logic [CW-1:0]                leq_cnt;
    logic [CW-1:0]                half;

    // length register: out-of-range contents fall back to the maximum
    assign len_w   = LW'(len_reg);
    assign len_eff = ((len_w == '0) || (len_w > MAX_W)) ? CW'(WINDOW_MAX) : CW'(len_w);
    assign cfg_ok  = cfg_we && (cfg_wdata != '0) && cfg_wdata[0] && (LW'(cfg_wdata) <= MAX_W);

    assign head_inc = {1'b0, head_reg} + (CW+1)'(1);

    always_comb
    begin
        head_next   = head_reg;
        filled_next = filled_reg;
        priority if (cfg_ok || cmd.clear)
        begin
            head_next   = '0;
            filled_next = '0;
        end
        else if (cmd.push)
        begin
            head_next = (head_inc >= {1'b0, len_eff}) ? '0 : head_inc[CW-1:0];
            if (filled_reg < len_eff)
                filled_next = filled_reg + CW'(1);
        end
        else
        begin
            head_next   = head_reg;
            filled_next = filled_reg;
        end
    end

    always_comb
    begin
        priority if (cmd.push)
            cand_next = '0;
        else if (cmd.rank_next)
            cand_next = cand_reg + CW'(1);
        else
            cand_next = cand_reg;
    end

    // rank of the current candidate among the filled slots
    assign cand_val = window_reg[cand_reg[IW-1:0]];
    assign half     = filled_reg >> 1;

    always_comb
    begin
        less_cnt = '0;
        leq_cnt  = '0;
        for (int j = 0; j < WINDOW_MAX; j++)
        begin
            if (CW'(j) < filled_reg)
            begin
                if (window_reg[j] < cand_val)
                    less_cnt = less_cnt + CW'(1);
                if (window_reg[j] <= cand_val)
                    leq_cnt = leq_cnt + CW'(1);
            end
        end
    end

    assign st.found = (less_cnt <= half) && (leq_cnt > half);

    always_ff @(posedge clk)
    begin
        if (cmd.push)
            window_reg[head_reg[IW-1:0]] <= in_item.sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= swm_pkg::LEN_RESET;
            head_reg   <= '0;
            filled_reg <= '0;
            cand_reg   <= '0;
        end
        else
        begin
            if (cfg_ok)
                len_reg <= cfg_wdata;
            head_reg   <= head_next;
            filled_reg <= filled_next;
            cand_reg   <= cand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            res_median_reg <= '0;
            res_fill_reg   <= '0;
            res_valid_reg  <= 1'b0;
        end
        else if (cmd.capture)
        begin
            res_median_reg <= cand_val;
            res_fill_reg   <= filled_reg;
            res_valid_reg  <= 1'b1;
        end
        if (cmd.load_out)
        begin
            out_item_reg.median       <= res_median_reg;
            out_item_reg.fill_count   <= swm_pkg::FILL_BITS'(res_fill_reg);
            out_item_reg.median_valid <= res_valid_reg;
        end
    end

    assign out_item = out_item_reg;

`ifndef SYNTHESIS
    a_fill_in_len: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= len_eff)
        else $error("fill count above window length");

    a_head_in_len: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg < len_eff)
        else $error("write head outside window");

    a_cand_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rank_next || cmd.capture) |-> (cand_reg < filled_reg))
        else $error("rank candidate outside filled slots");

    a_rank_hits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rank_next |-> (({1'b0, cand_reg} + (CW+1)'(1)) < {1'b0, filled_reg}))
        else $error("rank search ran past last filled slot");
`endif

endmodule

`default_nettype wire
